[src/pwt_pkg.sv]
// ----------------------------------------------------------------------------
// pwt_pkg
// shared widths, register indexes, reset values and status types for the
// pid controller with measured time interval
// ----------------------------------------------------------------------------
`default_nettype none

package pwt_pkg;

	localparam int ANGLE_W  = 24;
	localparam int TIME_W   = 32;
	localparam int GAIN_W   = 32;
	localparam int ERR_W    = 25;
	localparam int DERR_W   = 26;
	localparam int INTEG_W  = 48;
	localparam int DRIVE_W  = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// shared multiplier operand and product widths
	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;

	// divider: numerator is gain times error change
	localparam int NUM_W = GAIN_W + DERR_W;
	localparam int DEN_W = TIME_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN    = 3'd0,
		REG_INTEG_GAIN   = 3'd1,
		REG_DERIV_GAIN   = 3'd2,
		REG_DRIVE_OFFSET = 3'd3,
		REG_TARGET_ANGLE = 3'd4
	} reg_idx_t;

	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 32'd65536;
	localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST   = 32'd328;
	localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST   = 32'd0;
	localparam logic [ANGLE_W-1:0] DRIVE_OFFSET_RST = 24'd0;
	localparam logic [ANGLE_W-1:0] TARGET_ANGLE_RST = 24'd23040;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

[src/pwt_mul.sv]
// ----------------------------------------------------------------------------
// pwt_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
`default_nettype none

module pwt_mul (
	input  wire logic                                clk,
	input  wire logic signed [pwt_pkg::MUL_W-1:0]    a,
	input  wire logic signed [pwt_pkg::MUL_W-1:0]    b,
	output logic signed [pwt_pkg::PROD_W-1:0]        p
);
	import pwt_pkg::*;

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

`default_nettype wire

[src/pwt_div.sv]
// ----------------------------------------------------------------------------
// pwt_div
// radix-2 restoring divider, signed numerator over unsigned denominator,
// quotient truncated toward zero, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pwt_div (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic signed [pwt_pkg::NUM_W-1:0]   num,
	input  wire logic [pwt_pkg::DEN_W-1:0]          den,
	output pwt_pkg::div_stat_t                      stat,
	output logic signed [pwt_pkg::NUM_W-1:0]        quot
);
	import pwt_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             neg_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W+1:0] diff;
	logic [NUM_W-1:0] mag;

	assign mag     = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign shifted = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag;
			den_q <= den;
			neg_q <= num[NUM_W-1];
		end else if (busy_q) begin
			if (!diff[DEN_W+1]) begin
				rem_q <= diff[DEN_W:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quot      = neg_q ? -$signed(quo_q) : $signed(quo_q);
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

[src/pid_with_time_interval.sv]
// ----------------------------------------------------------------------------
// pid_with_time_interval
// fixed-point pid controller that measures the sample interval from
// millisecond timestamps; one shared multiplier and a serial divider
// ----------------------------------------------------------------------------
// An item's result is valid later when the timestamp advanced than when the
// interval is zero, since only then does the derivative divider run; the
// input is ready again in the cycle the result appears. The derivative
// divider retires one quotient bit per cycle over 58 steps; the five
// products go through one 33x33 multiplier, the two integral products while
// the division runs. The input is not ready until the result of the previous
// item has been loaded into the output register.
`default_nettype none

module pid_with_time_interval (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [pwt_pkg::ANGLE_W-1:0]    angle,
	input  wire logic [pwt_pkg::TIME_W-1:0]            time_ms,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [pwt_pkg::DRIVE_W-1:0]         drive,
	output logic signed [pwt_pkg::ERR_W-1:0]           err_now,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [pwt_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [pwt_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import pwt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_WAIT, S_ADD, S_FIN
	} state_t;

	localparam logic signed [INTEG_W+18:0] INTEG_MAX = 67'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [INTEG_W+18:0] INTEG_MIN = -67'sh0_8000_0000_0000;
	localparam logic signed [PROD_W-1:0] DRIVE_MAX = 66'sh0_7FFF_FFFF;
	localparam logic signed [PROD_W-1:0] DRIVE_MIN = -66'sh0_8000_0000;

	state_t state_q;

	logic signed [GAIN_W-1:0]  prop_gain_q, integ_gain_q, deriv_gain_q;
	logic signed [ANGLE_W-1:0] drive_offset_q, target_angle_q;

	logic signed [ERR_W-1:0]   last_error_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic [TIME_W-1:0]         last_time_q;

	logic signed [ERR_W-1:0]   err_q;
	logic signed [DERR_W-1:0]  derr_q;
	logic [TIME_W-1:0]         interval_q;
	logic signed [PROD_W-1:0]  acc_q;
	logic signed [PROD_W-1:0]  hi_q;

	logic                      out_valid_q;
	logic signed [DRIVE_W-1:0] drive_q;
	logic signed [ERR_W-1:0]   err_now_q;

	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic                      div_start;
	div_stat_t                 div_stat;
	logic signed [NUM_W-1:0]   dterm;

	logic signed [ERR_W-1:0]     err_in;
	logic signed [INTEG_W+18:0]  integ_sum;
	logic signed [PROD_W-1:0]    drive_sum;
	logic                        in_xfer;
	logic                        out_free;

	pwt_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	pwt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod[NUM_W-1:0]),
		.den    (interval_q),
		.stat   (div_stat),
		.quot   (dterm)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign div_start = (state_q == S_M3) && (interval_q != '0);

	assign err_in = ERR_W'(target_angle_q) - ERR_W'(angle);

	// operand select for the shared multiplier
	always_comb begin
		case (state_q)
			S_M1: begin
				mul_a = MUL_W'(err_q);
				mul_b = $signed({1'b0, interval_q});
			end
			S_M2: begin
				mul_a = MUL_W'(deriv_gain_q);
				mul_b = MUL_W'(derr_q);
			end
			S_M3: begin
				mul_a = MUL_W'(prop_gain_q);
				mul_b = MUL_W'(err_q);
			end
			S_M4: begin
				mul_a = MUL_W'(integ_gain_q);
				mul_b = $signed({17'd0, integ_q[15:0]});
			end
			S_M5: begin
				mul_a = MUL_W'(integ_gain_q);
				mul_b = MUL_W'($signed(integ_q[INTEG_W-1:16]));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign integ_sum = (INTEG_W+19)'(integ_q) + (INTEG_W+19)'(prod);
	assign drive_sum = hi_q + PROD_W'(drive_offset_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q    <= PROP_GAIN_RST;
			integ_gain_q   <= INTEG_GAIN_RST;
			deriv_gain_q   <= DERIV_GAIN_RST;
			drive_offset_q <= DRIVE_OFFSET_RST;
			target_angle_q <= TARGET_ANGLE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PROP_GAIN:    prop_gain_q    <= cfg_data;
				REG_INTEG_GAIN:   integ_gain_q   <= cfg_data;
				REG_DERIV_GAIN:   deriv_gain_q   <= cfg_data;
				REG_DRIVE_OFFSET: drive_offset_q <= cfg_data[ANGLE_W-1:0];
				REG_TARGET_ANGLE: target_angle_q <= cfg_data[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			last_error_q <= '0;
			integ_q      <= '0;
			last_time_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if ((state_q == S_FIN) && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						err_q        <= err_in;
						derr_q       <= DERR_W'(err_in) - DERR_W'(last_error_q);
						interval_q   <= time_ms - last_time_q;
						last_error_q <= err_in;
						last_time_q  <= time_ms;
						state_q      <= S_M1;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: begin
					if (integ_sum > INTEG_MAX)
						integ_q <= INTEG_MAX[INTEG_W-1:0];
					else if (integ_sum < INTEG_MIN)
						integ_q <= INTEG_MIN[INTEG_W-1:0];
					else
						integ_q <= integ_sum[INTEG_W-1:0];
					state_q <= S_M3;
				end
				S_M3: state_q <= S_M4;
				S_M4: begin
					acc_q   <= prod;
					state_q <= S_M5;
				end
				S_M5: begin
					acc_q   <= acc_q + prod;
					state_q <= S_M6;
				end
				S_M6: begin
					hi_q    <= prod;
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (interval_q == '0) begin
						state_q <= S_ADD;
					end else if (div_stat.done) begin
						acc_q   <= acc_q + PROD_W'(dterm);
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					hi_q    <= hi_q + (acc_q >>> 16);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						if (drive_sum > DRIVE_MAX)
							drive_q <= DRIVE_MAX[DRIVE_W-1:0];
						else if (drive_sum < DRIVE_MIN)
							drive_q <= DRIVE_MIN[DRIVE_W-1:0];
						else
							drive_q <= drive_sum[DRIVE_W-1:0];
						err_now_q   <= err_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign err_now   = err_now_q;

	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_stat.busy)
		else $error("divider busy while waiting for input");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("input ready right after a transfer");

	a_div_nonzero_den: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (interval_q != '0))
		else $error("divider running on a zero interval");

	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) && out_free |=> out_valid_q && in_ready)
		else $error("result not loaded on completion");

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for pid_with_time_interval. A directed stimulus table covers
// reset values, angle and gain extremes, zero, huge and wrapping intervals,
// integral and drive saturation and writes to unused register indexes. Then
// come phases of random samples, each under a new register setting. Every
// result transfer is checked field by field against an in-bench controller
// model, or typed rows' table values, with random stalls on input and result.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pwt_pkg::*;

	localparam int IDLE_PCT       = 14;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = 150;
	localparam int PHASES         = 10;
	localparam int PHASE_CALM     = 4;

	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

	localparam longint INTEG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint INTEG_MIN = -INTEG_MAX - 1;
	localparam longint DRIVE_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam longint DRIVE_MIN = -DRIVE_MAX - 1;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic signed [ERR_W-1:0]   err;
	} pid_result_t;

	typedef enum logic {
		ROW_SAMPLE,
		ROW_WRITE
	} row_kind_t;

	typedef struct {
		row_kind_t                   kind;
		logic [CFG_IDX_W-1:0]        idx;
		logic [CFG_DATA_W-1:0]       data;
		logic signed [ANGLE_W-1:0]   ang;
		logic [TIME_W-1:0]           stamp;
		logic                        typed;
		logic signed [DRIVE_W-1:0]   exp_drive;
		logic signed [ERR_W-1:0]     exp_err;
	} stim_row_t;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_ready;
	logic signed [ANGLE_W-1:0]   angle     = '0;
	logic [TIME_W-1:0]           time_ms   = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic signed [DRIVE_W-1:0]   drive;
	logic signed [ERR_W-1:0]     err_now;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]       cfg_data  = '0;

	// controller model: registers and state
	logic signed [GAIN_W-1:0]    cf_kp     = PROP_GAIN_RST;
	logic signed [GAIN_W-1:0]    cf_ki     = INTEG_GAIN_RST;
	logic signed [GAIN_W-1:0]    cf_kd     = DERIV_GAIN_RST;
	logic signed [ANGLE_W-1:0]   cf_offset = DRIVE_OFFSET_RST;
	logic signed [ANGLE_W-1:0]   cf_target = TARGET_ANGLE_RST;
	longint                      st_last_err  = 0;
	longint                      st_integ     = 0;
	logic [TIME_W-1:0]           st_last_time = '0;

	pid_result_t pending_results[$];
	stim_row_t   stim_rows[$];
	int          mismatches   = 0;
	int          stall_cycles = 0;
	bit          calm         = 1'b0;

	pid_with_time_interval dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.angle     (angle),
		.time_ms   (time_ms),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive     (drive),
		.err_now   (err_now),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_PROP_GAIN:    cf_kp = data;
			REG_INTEG_GAIN:   cf_ki = data;
			REG_DERIV_GAIN:   cf_kd = data;
			REG_DRIVE_OFFSET: cf_offset = data[ANGLE_W-1:0];
			REG_TARGET_ANGLE: cf_target = data[ANGLE_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic pid_result_t step_controller(input logic signed [ANGLE_W-1:0] ang,
			input logic [TIME_W-1:0] stamp);
		logic [TIME_W-1:0] ivl;
		longint err, sum, dterm, ih, il, low, drv;
		pid_result_t r;
		ivl = stamp - st_last_time;
		err = longint'(cf_target) - longint'(ang);
		st_last_time = stamp;
		sum = st_integ + err * longint'({32'b0, ivl});
		if (sum > INTEG_MAX)
			sum = INTEG_MAX;
		if (sum < INTEG_MIN)
			sum = INTEG_MIN;
		st_integ = sum;
		dterm = 0;
		if (ivl != 0)
			dterm = (longint'(cf_kd) * (err - st_last_err)) / longint'({32'b0, ivl});
		st_last_err = err;
		// split the integral so no product leaves 64 bits
		ih = sum >>> 16;
		il = sum - (ih <<< 16);
		low = longint'(cf_kp) * err + longint'(cf_ki) * il + dterm;
		drv = longint'(cf_ki) * ih + (low >>> 16) + longint'(cf_offset);
		if (drv > DRIVE_MAX)
			drv = DRIVE_MAX;
		if (drv < DRIVE_MIN)
			drv = DRIVE_MIN;
		r.drive = drv[DRIVE_W-1:0];
		r.err = err[ERR_W-1:0];
		return r;
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		stim_row_t r;
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.data = data;
		r.ang = '0;
		r.stamp = '0;
		r.typed = 1'b0;
		r.exp_drive = '0;
		r.exp_err = '0;
		stim_rows.push_back(r);
	endfunction

	function automatic void add_sample(input logic signed [ANGLE_W-1:0] ang,
			input logic [TIME_W-1:0] stamp, input logic typed,
			input logic signed [DRIVE_W-1:0] exp_drive, input logic signed [ERR_W-1:0] exp_err);
		stim_row_t r;
		r.kind = ROW_SAMPLE;
		r.idx = '0;
		r.data = '0;
		r.ang = ang;
		r.stamp = stamp;
		r.typed = typed;
		r.exp_drive = exp_drive;
		r.exp_err = exp_err;
		stim_rows.push_back(r);
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		logic [GAIN_W-1:0] mag;
		mag = $urandom_range(0, 4 * 65536);
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3, 4: return $urandom;
			default: return $urandom_range(1) ? -mag : mag;
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_angle_reg(input int center, input int spread);
		int v;
		case ($urandom_range(5))
			0: v = 8388607;
			1: v = -8388608;
			2: v = $urandom;
			default: v = center + int'($urandom_range(0, 2 * spread)) - spread;
		endcase
		return {8'($urandom), v[ANGLE_W-1:0]};
	endfunction

	function automatic logic [ANGLE_W-1:0] pick_angle();
		int v;
		case ($urandom_range(9))
			7, 8: v = $urandom;
			9: v = $urandom_range(1) ? 8388607 : -8388608;
			default: v = int'(cf_target) + int'($urandom_range(0, 40000)) - 20000;
		endcase
		return v[ANGLE_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
		mismatches++;
	endtask

	// waits for the pipeline to drain, then one register transfer
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, data);
	endtask

	task automatic send_sample(input logic signed [ANGLE_W-1:0] ang, input logic [TIME_W-1:0] stamp,
			input logic typed, input logic signed [DRIVE_W-1:0] exp_drive,
			input logic signed [ERR_W-1:0] exp_err);
		pid_result_t r;
		int gap;
		cfg_valid <= 1'b0;
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			gap = $urandom_range(1, 80);
			repeat (gap) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		angle <= ang;
		time_ms <= stamp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = step_controller(ang, stamp);
		if (typed) begin
			r.drive = exp_drive;
			r.err = exp_err;
		end
		pending_results.push_back(r);
	endtask

	always @(posedge clk) begin
		pid_result_t want;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result transfer with nothing pending", drive, 0);
			end else begin
				want = pending_results.pop_front();
				if (drive !== want.drive)
					report_mismatch("drive", drive, want.drive);
				if (err_now !== want.err)
					report_mismatch("err_now", err_now, want.err);
			end
		end
		out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("pid_with_time_interval regression: fail");
			$finish;
		end
	end

	initial begin
		int j, ph, i, n_items;
		logic [TIME_W-1:0] clock_ms;
		logic [CFG_DATA_W-1:0] kp, ki, kd, off, tgt;

		// after reset, angle extremes, zero interval on the first sample
		add_sample(24'sd23040, 32'd0, 1'b1, 32'sd0, 25'sd0);
		add_sample(-24'sd8388608, 32'd0, 1'b1, 32'sd8411648, 25'sd8411648);
		add_sample(24'sd8388607, 32'd0, 1'b1, -32'sd8365567, -25'sd8365567);
		add_sample(24'sd0, 32'd1000, 1'b0, '0, '0);
		add_sample(24'sd100, 32'd1000, 1'b0, '0, '0);
		add_write(REG_DERIV_GAIN, 32'd3276800);
		add_sample(24'sd5000, 32'd1010, 1'b0, '0, '0);
		add_sample(-24'sd5000, 32'd1011, 1'b0, '0, '0);
		add_sample(24'sd0, 32'hFFFF_FFF0, 1'b0, '0, '0);
		// timestamp wrap
		add_sample(24'sd0, 32'h0000_0010, 1'b0, '0, '0);
		add_write(REG_PROP_GAIN, 32'h7FFF_FFFF);
		add_sample(-24'sd8388608, 32'h0000_0010, 1'b1, 32'sh7FFF_FFFF, 25'sd8411648);
		add_write(REG_PROP_GAIN, 32'h8000_0000);
		add_write(REG_INTEG_GAIN, 32'h8000_0000);
		add_sample(-24'sd8388608, 32'h0000_0014, 1'b0, '0, '0);
		// integral saturation both ways
		add_write(REG_TARGET_ANGLE, 32'h007F_FFFF);
		add_sample(-24'sd8388608, 32'h4000_0000, 1'b0, '0, '0);
		add_write(REG_TARGET_ANGLE, 32'h0080_0000);
		add_write(REG_INTEG_GAIN, 32'h7FFF_FFFF);
		add_write(REG_DERIV_GAIN, 32'h8000_0000);
		add_sample(24'sd8388607, 32'h8000_0000, 1'b0, '0, '0);
		add_write(REG_DRIVE_OFFSET, 32'h007F_FFFF);
		add_sample(24'sd0, 32'h8000_0001, 1'b0, '0, '0);
		add_write(REG_DRIVE_OFFSET, 32'h0080_0000);
		add_sample(24'sd0, 32'h8000_0001, 1'b0, '0, '0);
		add_write(REG_DERIV_GAIN, 32'h7FFF_FFFF);
		// unused indexes must leave the registers alone
		for (j = IDX_SPARE_LO; j <= IDX_SPARE_HI; j++)
			add_write(CFG_IDX_W'(j), 32'hFFFF_FFFF);
		add_sample(-24'sd1, 32'h8000_0003, 1'b0, '0, '0);
		// time going backwards gives an interval of almost 2^32
		add_sample(24'sd0, 32'h8000_0002, 1'b0, '0, '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[k]) begin
			if (stim_rows[k].kind == ROW_WRITE)
				write_reg(stim_rows[k].idx, stim_rows[k].data);
			else
				send_sample(stim_rows[k].ang, stim_rows[k].stamp, stim_rows[k].typed,
					stim_rows[k].exp_drive, stim_rows[k].exp_err);
		end

		clock_ms = 32'h8000_0002;
		for (ph = 0; ph < PHASES; ph++) begin
			calm = (ph == PHASE_CALM);
			if (ph == 0) begin
				kp = PROP_GAIN_RST;
				ki = INTEG_GAIN_RST;
				kd = DERIV_GAIN_RST;
				off = {8'h00, DRIVE_OFFSET_RST};
				tgt = {8'h00, TARGET_ANGLE_RST};
			end else if (ph == 1) begin
				kp = 32'h7FFF_FFFF;
				ki = 32'h7FFF_FFFF;
				kd = 32'h7FFF_FFFF;
				off = 32'h007F_FFFF;
				tgt = 32'h007F_FFFF;
			end else if (ph == 2) begin
				kp = 32'h8000_0000;
				ki = 32'h8000_0000;
				kd = 32'h8000_0000;
				off = 32'h0080_0000;
				tgt = 32'h0080_0000;
			end else begin
				kp = pick_gain();
				ki = pick_gain();
				kd = pick_gain();
				off = pick_angle_reg(0, 2000);
				tgt = pick_angle_reg(23040, 5000);
			end
			if ($urandom_range(2) == 0)
				write_reg(CFG_IDX_W'(IDX_SPARE_LO + $urandom_range(2)), $urandom);
			write_reg(REG_PROP_GAIN, kp);
			write_reg(REG_INTEG_GAIN, ki);
			write_reg(REG_DERIV_GAIN, kd);
			write_reg(REG_DRIVE_OFFSET, off);
			write_reg(REG_TARGET_ANGLE, tgt);

			n_items = $urandom_range(170, 230);
			for (i = 0; i < n_items; i++) begin
				case ($urandom_range(19))
					0, 1: clock_ms = clock_ms;
					2, 3: clock_ms = clock_ms + $urandom_range(21, 5000);
					4: clock_ms = clock_ms + $urandom;
					5: clock_ms = $urandom;
					6: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 30);
					default: clock_ms = clock_ms + $urandom_range(1, 20);
				endcase
				// hold off until every pending result is back
				if ($urandom_range(99) < 2 && pending_results.size() != 0) begin
					in_valid <= 1'b0;
					while (pending_results.size() != 0)
						@(posedge clk);
				end
				send_sample(pick_angle(), clock_ms, 1'b0, '0, '0);
			end
		end

		calm = 1'b0;
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("pid_with_time_interval regression: pass");
		else
			$display("pid_with_time_interval regression: fail");
		$finish;
	end

endmodule
